[sv/brf_pkg.sv]
package brf_pkg;

    localparam int KIND_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 11;
    localparam int LEVEL_W = 11;

    // Operation codes carried in the kind field.
    localparam logic [KIND_W-1:0] KIND_WRITE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DROP  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

    localparam logic [LEVEL_W-1:0] CAPACITY_RESET = 11'd1024;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  byte_in;
        logic [COUNT_W-1:0] count;
    } brf_cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  byte_out;
        logic               ok;
        logic [LEVEL_W-1:0] fill_level;
        logic [LEVEL_W-1:0] space_left;
    } brf_res_t;

    // Result of one operation while its store read is still in flight.
    typedef struct packed {
        logic               use_byte;
        logic               ok;
        logic [LEVEL_W-1:0] fill_level;
        logic [LEVEL_W-1:0] space_left;
    } brf_pend_t;

endpackage

[sv/byte_ring_fifo_unit.sv]
// Channel  Direction  Handshake              Payload
// cmd      in         cmd_valid / cmd_ready  brf_cmd_t: kind, byte_in, count
// res      out        res_valid / res_ready  brf_res_t: byte_out, ok, fill_level, space_left
// cfg      in         cfg_valid / cfg_ready  cfg_capacity, 11 bits
//
// One operation is accepted every cycle while cmd_ready is high. Its result passes through
// the stage register, alongside the registered read of the store, into the result register,
// from which it transfers.
// Reset empties the queue and sets the capacity to 1024; the store is not cleared.
// A stalled result holds the result register; one more operation can wait in the
// stage behind it before cmd_ready falls.
// The capacity port is always ready.
module byte_ring_fifo_unit
    import brf_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  brf_cmd_t           cmd,
    output logic               res_valid,
    input  logic               res_ready,
    output brf_res_t           res,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LEVEL_W-1:0] cfg_capacity
);

    localparam int PW = $clog2(DEPTH);

    logic              accept;
    logic              ram_en, ram_we;
    logic [PW-1:0]     ram_addr;
    logic [BYTE_W-1:0] ram_wdata, ram_rdata;
    brf_pend_t         pend;

    // The pointer state moves at the command transfer itself; only the byte
    // from the store comes later, from a registered read, so back-to-back operations see
    // each other's effects without forwarding. Each operation touches the
    // store at most once, so a single port is enough.
    assign accept    = cmd_valid && cmd_ready;
    assign cfg_ready = 1'b1;

    brf_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_capacity(cfg_capacity),
        .accept      (accept),
        .cmd         (cmd),
        .ram_en      (ram_en),
        .ram_we      (ram_we),
        .ram_addr    (ram_addr),
        .ram_wdata   (ram_wdata),
        .pend        (pend)
    );

    brf_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(DEPTH)
    ) u_store (
        .clk  (clk),
        .en   (ram_en),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    // The read data register only changes when a new read is issued, which
    // cannot happen while the in-flight stage is stalled.
    brf_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .pend      (pend),
        .ram_rdata (ram_rdata),
        .take_ready(cmd_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

[sv/brf_ram.sv]
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // The read data register changes only on a read, so it holds while the
    // consumer stalls.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/brf_ctrl.sv]
module brf_ctrl
    import brf_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [LEVEL_W-1:0]       cfg_capacity,
    input  logic                     accept,
    input  brf_cmd_t                 cmd,
    output logic                     ram_en,
    output logic                     ram_we,
    output logic [$clog2(DEPTH)-1:0] ram_addr,
    output logic [BYTE_W-1:0]        ram_wdata,
    output brf_pend_t                pend
);

    localparam int PW = $clog2(DEPTH);
    localparam int AW = ((PW > LEVEL_W) ? PW : LEVEL_W) + 1;
    localparam logic [AW-1:0] DEPTH_A = AW'(DEPTH);

    logic [LEVEL_W-1:0] capacity_reg;
    logic [PW-1:0]      wr_pos_reg, wr_pos_next;
    logic [PW-1:0]      rd_pos_reg, rd_pos_next;
    logic [LEVEL_W-1:0] fill_reg, fill_next;

    logic [AW-1:0] cap_raw, cap_a, fill_a, count_a, rd_a, wr_a, drop_n;
    logic          op_en, op_we;
    logic [PW-1:0] op_addr;

    // Position step with a single wrap; pos < cap and n <= cap.
    function automatic logic [AW-1:0] advance(input logic [AW-1:0] pos,
                                              input logic [AW-1:0] n,
                                              input logic [AW-1:0] cap);
        logic [AW-1:0] s;
        s = pos + n;
        if (s >= cap)
        begin
            s = s - cap;
        end
        return s;
    endfunction

    always_comb
    begin
        cap_raw = AW'(capacity_reg);
        if (cap_raw == '0)
        begin
            cap_a = AW'(1);
        end
        else if (cap_raw > DEPTH_A)
        begin
            cap_a = DEPTH_A;
        end
        else
        begin
            cap_a = cap_raw;
        end
    end

    always_comb
    begin
        fill_a  = AW'(fill_reg);
        count_a = AW'(cmd.count);
        rd_a    = AW'(rd_pos_reg);
        wr_a    = AW'(wr_pos_reg);
        drop_n  = (count_a > fill_a) ? fill_a : count_a;

        wr_pos_next   = wr_pos_reg;
        rd_pos_next   = rd_pos_reg;
        fill_next     = fill_reg;
        op_en         = 1'b0;
        op_we         = 1'b0;
        op_addr       = rd_pos_reg;
        pend.use_byte = 1'b0;
        pend.ok       = 1'b0;

        case (cmd.kind)
            KIND_WRITE:
            begin
                if (fill_a < cap_a)
                begin
                    op_en       = 1'b1;
                    op_we       = 1'b1;
                    op_addr     = wr_pos_reg;
                    wr_pos_next = PW'(advance(wr_a, AW'(1), cap_a));
                    fill_next   = fill_reg + LEVEL_W'(1);
                    pend.ok     = 1'b1;
                end
            end
            KIND_READ:
            begin
                if (fill_reg != '0)
                begin
                    op_en         = 1'b1;
                    op_addr       = rd_pos_reg;
                    rd_pos_next   = PW'(advance(rd_a, AW'(1), cap_a));
                    fill_next     = fill_reg - LEVEL_W'(1);
                    pend.ok       = 1'b1;
                    pend.use_byte = 1'b1;
                end
            end
            KIND_PEEK:
            begin
                if (count_a < fill_a)
                begin
                    op_en         = 1'b1;
                    op_addr       = PW'(advance(rd_a, count_a, cap_a));
                    pend.ok       = 1'b1;
                    pend.use_byte = 1'b1;
                end
            end
            KIND_DROP:
            begin
                rd_pos_next = PW'(advance(rd_a, drop_n, cap_a));
                fill_next   = fill_reg - LEVEL_W'(drop_n);
                pend.ok     = (count_a <= fill_a);
            end
            KIND_CLEAR:
            begin
                wr_pos_next = '0;
                rd_pos_next = '0;
                fill_next   = '0;
                pend.ok     = 1'b1;
            end
            default:
            begin
            end
        endcase

        pend.fill_level = fill_next;
        pend.space_left = LEVEL_W'(cap_a - AW'(fill_next));
    end

    assign ram_en    = accept && op_en;
    assign ram_we    = op_we;
    assign ram_addr  = op_addr;
    assign ram_wdata = cmd.byte_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
            wr_pos_reg   <= '0;
            rd_pos_reg   <= '0;
            fill_reg     <= '0;
        end
        else if (cfg_write)
        begin
            // A new capacity also empties the queue.
            capacity_reg <= cfg_capacity;
            wr_pos_reg   <= '0;
            rd_pos_reg   <= '0;
            fill_reg     <= '0;
        end
        else if (accept)
        begin
            wr_pos_reg <= wr_pos_next;
            rd_pos_reg <= rd_pos_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

[sv/brf_out_stage.sv]
module brf_out_stage
    import brf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  brf_pend_t         pend,
    input  logic [BYTE_W-1:0] ram_rdata,
    output logic              take_ready,
    output logic              res_valid,
    input  logic              res_ready,
    output brf_res_t          res
);

    logic      s1_valid_reg;
    brf_pend_t s1_pend_reg;
    logic      out_valid_reg;
    brf_res_t  out_reg;
    logic      out_free, s1_adv;

    assign out_free   = !out_valid_reg || res_ready;
    assign s1_adv     = s1_valid_reg && out_free;
    assign take_ready = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pend_reg <= pend;
        end
        if (s1_adv)
        begin
            out_reg.byte_out   <= s1_pend_reg.use_byte ? ram_rdata : '0;
            out_reg.ok         <= s1_pend_reg.ok;
            out_reg.fill_level <= s1_pend_reg.fill_level;
            out_reg.space_left <= s1_pend_reg.space_left;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

[sv/brf_checker.sv]
module brf_checker
    import brf_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input logic     clk,
    input logic     rst_n,
    input logic     cmd_valid,
    input logic     cmd_ready,
    input logic     res_valid,
    input logic     res_ready,
    input brf_res_t res
);

    logic [1:0] open_reg;
    logic       cmd_xfer, res_xfer;

    assign cmd_xfer = cmd_valid && cmd_ready;
    assign res_xfer = res_valid && res_ready;

    // Operations accepted whose results are not yet transferred.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else if (cmd_xfer && !res_xfer)
        begin
            open_reg <= open_reg + 2'd1;
        end
        else if (res_xfer && !cmd_xfer)
        begin
            open_reg <= open_reg - 2'd1;
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid |-> open_reg != 2'd0) && open_reg != 2'd3)
        else $error("result without a pending operation or too many in flight");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.ok |-> res.byte_out == '0)
        else $error("byte_out not zero on a failed operation");

    a_levels: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (32'(res.fill_level) + 32'(res.space_left) >= 1)
                   && (32'(res.fill_level) + 32'(res.space_left) <= DEPTH))
        else $error("fill plus space outside the capacity range");

endmodule

bind byte_ring_fifo_unit brf_checker #(.DEPTH(DEPTH)) u_brf_checker (.*);

[verif/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import brf_pkg::*;

    // Store size of the instance and the limits of the register and count field.
    localparam int unsigned MEM_DEPTH = 1024;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [LEVEL_W-1:0] CAP_WORD_MAX = '1;

    // Kind codes that the block treats as no operation.
    localparam logic [KIND_W-1:0] KIND_RSVD_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_RSVD_MID = 3'd6;
    localparam logic [KIND_W-1:0] KIND_RSVD_LAST = 3'd7;

    // The result is registered in the stage register and then in the result register
    // after the command transfer, so SETTLE_CYCLES of quiet after the last result are
    // plenty before the register is touched.
    localparam int SETTLE_CYCLES = 6;
    localparam int unsigned CYCLE_LIMIT = 500000;

    // Long receiver hold-offs, started when the result count reaches these marks.
    localparam int unsigned CHOKE_AT_A = 150;
    localparam int unsigned CHOKE_AT_B = 700;
    localparam int LONG_HOLD = 400;

    localparam int PHASES = 11;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic cmd_valid = 1'b0;
    logic cmd_ready;
    brf_cmd_t cmd = '0;

    logic res_valid;
    logic res_ready = 1'b0;
    brf_res_t res;

    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [LEVEL_W-1:0] cfg_capacity = '0;

    byte_ring_fifo_unit #(
        .DEPTH(MEM_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd(cmd),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res(res),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_capacity(cfg_capacity)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Shadow copy of the ring. It is advanced once per command transfer, in
    // transfer order, and the result it gives is queued for the monitor.
    // ------------------------------------------------------------------------
    logic [BYTE_W-1:0] mirror_mem [0:MEM_DEPTH-1];
    int unsigned wr_idx = 0;
    int unsigned rd_idx = 0;
    int unsigned level = 0;
    int unsigned cap_reg = 32'(CAPACITY_RESET);

    brf_cmd_t op_queue [$];
    brf_res_t fifo_expect_q [$];

    int errors = 0;
    int unsigned cycle_count = 0;
    int unsigned results_seen = 0;

    // A register value of zero behaves as one byte; anything past the store
    // behaves as the whole store.
    function automatic int unsigned usable_bytes(int unsigned word);
        if (word == 0)
        begin
            return 1;
        end
        return (word > MEM_DEPTH) ? MEM_DEPTH : word;
    endfunction

    // Positions wrap at the capacity in use, which need not be a power of two.
    function automatic int unsigned wrap_add(int unsigned pos, int unsigned n,
                                             int unsigned lim);
        return (pos + n >= lim) ? pos + n - lim : pos + n;
    endfunction

    function automatic brf_res_t apply_op(brf_cmd_t op);
        int unsigned lim;
        int unsigned n;
        brf_res_t r;
        lim = usable_bytes(cap_reg);
        r = '0;
        case (op.kind)
            KIND_WRITE:
            begin
                if (level < lim)
                begin
                    mirror_mem[wr_idx] = op.byte_in;
                    wr_idx = wrap_add(wr_idx, 1, lim);
                    level++;
                    r.ok = 1'b1;
                end
            end
            KIND_READ:
            begin
                if (level > 0)
                begin
                    r.byte_out = mirror_mem[rd_idx];
                    rd_idx = wrap_add(rd_idx, 1, lim);
                    level--;
                    r.ok = 1'b1;
                end
            end
            KIND_PEEK:
            begin
                if (32'(op.count) < level)
                begin
                    r.byte_out = mirror_mem[wrap_add(rd_idx, 32'(op.count), lim)];
                    r.ok = 1'b1;
                end
            end
            KIND_DROP:
            begin
                // A drop larger than the fill level empties the queue and
                // reports that it was cut short.
                n = 32'(op.count);
                r.ok = 1'b1;
                if (n > level)
                begin
                    n = level;
                    r.ok = 1'b0;
                end
                rd_idx = wrap_add(rd_idx, n, lim);
                level -= n;
            end
            KIND_CLEAR:
            begin
                wr_idx = 0;
                rd_idx = 0;
                level = 0;
                r.ok = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.fill_level = LEVEL_W'(level);
        r.space_left = LEVEL_W'(lim - level);
        return r;
    endfunction

    // Most pauses are absent or short; a few are long.
    function automatic int pick_pause();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            return 0;
        end
        if (roll < 85)
        begin
            return $urandom_range(1, 2);
        end
        if (roll < 97)
        begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(15, 50);
    endfunction

    function automatic void push_op(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] value,
                                    logic [COUNT_W-1:0] count);
        brf_cmd_t op;
        op.kind = kind;
        op.byte_in = value;
        op.count = count;
        op_queue.push_back(op);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            if (errors < 40)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Command driver. A new command is loaded only when the channel is empty or
    // its current command transfers at this edge, so valid and the payload hold
    // steady while the block stalls. Gaps come between commands, with bursts
    // of back-to-back traffic now and then.
    // ------------------------------------------------------------------------
    int send_wait = 0;
    int send_calm = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd <= '0;
            send_wait = 0;
            send_calm = 0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
            begin
                fifo_expect_q.push_back(apply_op(cmd));
            end
            if (!cmd_valid || cmd_ready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    cmd_valid <= 1'b0;
                end
                else if (op_queue.size() > 0)
                begin
                    cmd <= op_queue.pop_front();
                    cmd_valid <= 1'b1;
                    if (send_calm > 0)
                    begin
                        send_calm--;
                    end
                    else if ($urandom_range(0, 99) < 2)
                    begin
                        send_calm = $urandom_range(20, 80);
                    end
                    else
                    begin
                        send_wait = pick_pause();
                    end
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor. Each result transfer is compared with the oldest queued
    // prediction. Ready drops at random, and twice it stays low for a long
    // stretch so the result stage and the stage behind it fill and cmd_ready
    // falls while the driver keeps offering commands.
    // ------------------------------------------------------------------------
    int hold_left = 0;
    int take_calm = 0;
    brf_res_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
            hold_left = 0;
            take_calm = 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                results_seen++;
                if (results_seen == CHOKE_AT_A || results_seen == CHOKE_AT_B)
                begin
                    hold_left = LONG_HOLD;
                end
                if (fifo_expect_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected, got byte %0d ok %0d",
                             $time, res.byte_out, res.ok);
                    errors++;
                end
                else
                begin
                    want = fifo_expect_q.pop_front();
                    check_field("byte_out", 32'(want.byte_out), 32'(res.byte_out));
                    check_field("ok", 32'(want.ok), 32'(res.ok));
                    check_field("fill_level", 32'(want.fill_level), 32'(res.fill_level));
                    check_field("space_left", 32'(want.space_left), 32'(res.space_left));
                end
            end

            if (hold_left > 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else if (take_calm > 0)
            begin
                take_calm--;
                res_ready <= 1'b1;
            end
            else if ($urandom_range(0, 99) < 3)
            begin
                take_calm = $urandom_range(20, 80);
                res_ready <= 1'b1;
            end
            else if ($urandom_range(0, 99) < 30)
            begin
                hold_left = pick_pause();
                if (hold_left > 0)
                begin
                    hold_left--;
                    res_ready <= 1'b0;
                end
                else
                begin
                    res_ready <= 1'b1;
                end
            end
            else
            begin
                res_ready <= 1'b1;
            end
        end
    end

    // The run ends here if the block stops producing results.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // Waits until every queued command has transferred and every result has
    // arrived, then lets the pipeline settle.
    task automatic wait_drained();
        while (op_queue.size() != 0 || cmd_valid || fifo_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // A capacity write also empties the queue, so the shadow state is reset
    // at the same edge that the write transfers.
    task automatic set_capacity(input logic [LEVEL_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_capacity <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cap_reg = 32'(value);
        wr_idx = 0;
        rd_idx = 0;
        level = 0;
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus. A directed pass walks the corner cases on a four-byte ring,
    // then random phases run under several capacities, the out-of-range
    // register values among them. Small rings see full, empty and wrap often;
    // the mid-size phase is write heavy so it wraps at a non-power-of-two size.
    // ------------------------------------------------------------------------
    int unsigned phase_cap [PHASES] = '{1, 0, 2, 5, 2047, 300, 13, 1024, 64, 3, 0};
    int unsigned phase_len [PHASES] = '{70, 60, 70, 80, 100, 300, 80, 100, 80, 60, 80};
    int unsigned phase_wr_pct [PHASES] = '{45, 45, 45, 50, 60, 65, 50, 60, 50, 45, 50};

    initial
    begin
        int unsigned cap_word;
        int unsigned lim;
        int unsigned roll;
        int unsigned pick;
        logic [KIND_W-1:0] kind;
        logic [COUNT_W-1:0] count;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With the reset capacity: read from empty, and a drop that gets clamped.
        push_op(KIND_READ, 8'h00, '0);
        push_op(KIND_DROP, 8'h00, COUNT_MAX);

        set_capacity(11'd4);
        push_op(KIND_DROP, 8'h00, '0);
        push_op(KIND_PEEK, 8'h00, '0);
        // Fill to the brim, then one write too many.
        push_op(KIND_WRITE, 8'h00, '0);
        push_op(KIND_WRITE, 8'hFF, COUNT_MAX);
        push_op(KIND_WRITE, 8'hA5, '0);
        push_op(KIND_WRITE, 8'h5A, '0);
        push_op(KIND_WRITE, 8'h11, '0);
        // Peek at both ends of the queue and just past it.
        push_op(KIND_PEEK, 8'h00, 11'd0);
        push_op(KIND_PEEK, 8'h00, 11'd3);
        push_op(KIND_PEEK, 8'h00, 11'd4);
        push_op(KIND_PEEK, 8'hFF, COUNT_MAX);
        push_op(KIND_READ, 8'h00, '0);
        // The write position wraps, and the peek reaches across the wrap.
        push_op(KIND_WRITE, 8'h3C, '0);
        push_op(KIND_PEEK, 8'h00, 11'd3);
        push_op(KIND_DROP, 8'h00, 11'd2);
        push_op(KIND_DROP, 8'h00, 11'd1024);
        push_op(KIND_RSVD_FIRST, 8'hFF, COUNT_MAX);
        push_op(KIND_RSVD_MID, 8'h00, '0);
        push_op(KIND_RSVD_LAST, 8'h7E, 11'd1);
        push_op(KIND_WRITE, 8'h81, '0);
        push_op(KIND_CLEAR, 8'h00, '0);
        push_op(KIND_READ, 8'h00, '0);

        for (int p = 0; p < PHASES; p++)
        begin
            cap_word = (p == PHASES - 1) ? $urandom_range(6, MEM_DEPTH - 1) : phase_cap[p];
            set_capacity(LEVEL_W'(cap_word));
            lim = usable_bytes(cap_word);
            for (int i = 0; i < phase_len[p]; i++)
            begin
                count = COUNT_W'($urandom_range(0, COUNT_MAX));
                roll = $urandom_range(0, 99);
                if (roll < phase_wr_pct[p])
                begin
                    kind = KIND_WRITE;
                end
                else
                begin
                    roll = $urandom_range(0, 99);
                    pick = $urandom_range(0, 9);
                    if (roll < 40)
                    begin
                        kind = KIND_READ;
                    end
                    else if (roll < 66)
                    begin
                        // Peeks mostly land near the read end or within the ring.
                        kind = KIND_PEEK;
                        if (pick < 4)
                        begin
                            count = COUNT_W'($urandom_range(0, 7));
                        end
                        else if (pick < 8)
                        begin
                            count = COUNT_W'($urandom_range(0, lim));
                        end
                    end
                    else if (roll < 90)
                    begin
                        // Drops are mostly small so the queue does not keep emptying.
                        kind = KIND_DROP;
                        if (pick < 7)
                        begin
                            count = COUNT_W'($urandom_range(0, 3));
                        end
                        else if (pick < 9)
                        begin
                            count = COUNT_W'($urandom_range(0, lim));
                        end
                    end
                    else if (roll < 94)
                    begin
                        kind = KIND_CLEAR;
                    end
                    else
                    begin
                        kind = KIND_W'($urandom_range(KIND_RSVD_FIRST, KIND_RSVD_LAST));
                    end
                end
                push_op(kind, BYTE_W'($urandom_range(0, 255)), count);
            end
        end

        // The largest register value is written once more so every bit of the
        // capacity word is seen high after traffic too.
        set_capacity(CAP_WORD_MAX);
        push_op(KIND_WRITE, BYTE_W'($urandom_range(0, 255)), '0);
        push_op(KIND_READ, 8'h00, '0);

        wait_drained();
        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
